// ----- hdl/sorted_key_priority_queue_assert.svh -----
// Assertion macros shared by the sorted key priority queue RTL.
`ifndef SORTED_KEY_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_KEY_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled during reset.
`define SKPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled during reset.
`define SKPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/skpq_pkg.sv -----
// Package: types, codes and constants of the sorted key priority queue.
`default_nettype none
package skpq_pkg;
  localparam int CAPACITY_DEF          = 32;
  localparam int PAYLOAD_BYTES_MAX_DEF = 8;
  localparam int RESULT_LIMIT          = 32;
  localparam int CNT_W                 = $clog2(RESULT_LIMIT + 1);
  localparam int KEY_W                 = 32;
  localparam int PAY_W                 = 64;
  localparam int NB_W                  = 4;

  typedef enum logic [1:0] {
    CMD_ENQ   = 2'd0,
    CMD_DEQ   = 2'd1,
    CMD_RANGE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UPDATED = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic [NB_W-1:0]  nbytes;
  } entry_t;

  typedef struct packed {
    status_t          status;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic [NB_W-1:0]  nbytes;
    logic             last;
  } res_t;
endpackage
`default_nettype wire

// ----- hdl/skpq_if.sv -----
// Channel interfaces: command items in, result items out.
`default_nettype none
interface skpq_in_if;
  import skpq_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       cmd;
  logic [KEY_W-1:0] key;
  logic [KEY_W-1:0] range_end;
  logic [PAY_W-1:0] payload;
  logic [NB_W-1:0]  payload_bytes;
  modport source (output valid, cmd, key, range_end, payload, payload_bytes, input ready);
  modport sink   (input valid, cmd, key, range_end, payload, payload_bytes, output ready);
endinterface

interface skpq_out_if;
  import skpq_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [KEY_W-1:0] out_key;
  logic [PAY_W-1:0] out_payload;
  logic [NB_W-1:0]  out_payload_bytes;
  logic             last;
  modport source (output valid, status, out_key, out_payload, out_payload_bytes, last,
                  input ready);
  modport sink   (input valid, status, out_key, out_payload, out_payload_bytes, last,
                  output ready);
endinterface
`default_nettype wire

// ----- hdl/skpq_store.sv -----
// Entry store: one write port, one read port with registered read data.
`default_nettype none
module skpq_store
  import skpq_pkg::*;
#(
  parameter int DEPTH = CAPACITY_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data
);
  entry_t mem [DEPTH];
  entry_t rd_data_r;

  // Write entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read entry, hold data when not reading
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule
`default_nettype wire

// ----- hdl/sorted_key_priority_queue.sv -----
// Per item: an enqueue searches for the insert slot, decides, shifts the entries from the slot
// up by one and writes the new entry, then closes; an update or a full queue closes on decision.
// Dequeue reads the head, shifts each later entry down by one, then closes; an empty dequeue
// only closes; a range query scans, then closes. One item at a time; output stalls add delay.
// Reset: rst_n low clears occupancy, the sequencer and the output valid; the store is unset.
`default_nettype none
`include "sorted_key_priority_queue_assert.svh"
module sorted_key_priority_queue
  import skpq_pkg::*;
#(
  parameter int CAPACITY          = CAPACITY_DEF,
  parameter int PAYLOAD_BYTES_MAX = PAYLOAD_BYTES_MAX_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  skpq_in_if.sink    in_ch,
  skpq_out_if.source out_ch
);
  localparam int AW = $clog2(CAPACITY);
  localparam int OW = $clog2(CAPACITY + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_EDEC = 6'b000100,
    S_SHU  = 6'b001000,
    S_DEQ  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [OW-1:0]    occ_r, occ_nxt;
  logic [OW-1:0]    idx_r, idx_nxt;
  logic [OW-1:0]    cidx_r, cidx_nxt;
  logic [OW-1:0]    pos_r, pos_nxt;
  logic             dv_r, dv_nxt;
  logic             eq_r, eq_nxt;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [KEY_W-1:0] hi_r, hi_nxt;
  entry_t           new_r, new_nxt;
  res_t             res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_res_r, out_res_nxt;

  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  entry_t           rd_data, wr_data;
  logic             push;
  res_t             push_res;
  logic             out_free;
  logic             in_acc;
  logic [NB_W-1:0]  nsat;
  logic [PAY_W-1:0] pay_masked;

  skpq_store #(.DEPTH(CAPACITY)) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Saturate the byte count and drop payload bytes above it
  always_comb begin
    if (in_ch.payload_bytes > NB_W'(PAYLOAD_BYTES_MAX)) begin
      nsat = NB_W'(PAYLOAD_BYTES_MAX);
    end else begin
      nsat = in_ch.payload_bytes;
    end
    for (int b = 0; b < PAY_W / 8; b++) begin
      pay_masked[8*b +: 8] = (NB_W'(b) < nsat) ? in_ch.payload[8*b +: 8] : 8'h00;
    end
  end

  // Sequence the search, shift and scan passes over the store
  always_comb begin
    state_nxt = state_r;
    occ_nxt   = occ_r;
    idx_nxt   = idx_r;
    cidx_nxt  = cidx_r;
    pos_nxt   = pos_r;
    dv_nxt    = 1'b0;
    eq_nxt    = eq_r;
    pend_nxt  = pend_r;
    cnt_nxt   = cnt_r;
    cmd_nxt   = cmd_r;
    hi_nxt    = hi_r;
    new_nxt   = new_r;
    res_nxt   = res_r;
    rd_en     = 1'b0;
    rd_addr   = idx_r[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = cidx_r[AW-1:0];
    wr_data   = rd_data;
    push      = 1'b0;
    push_res  = res_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt  = cmd_t'(in_ch.cmd);
          hi_nxt   = in_ch.range_end;
          new_nxt  = '{key: in_ch.key, payload: pay_masked, nbytes: nsat};
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          cnt_nxt  = '0;
          res_nxt  = '{status: ST_EMPTY, key: '0, payload: '0, nbytes: '0, last: 1'b1};
          case (cmd_t'(in_ch.cmd))
            CMD_ENQ, CMD_RANGE: state_nxt = S_SCAN;
            CMD_DEQ:            state_nxt = (occ_r == '0) ? S_FIN : S_DEQ;
            default:            state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        logic stop, stall;
        stop  = 1'b0;
        stall = 1'b0;
        if (dv_r) begin
          if (cmd_r == CMD_ENQ) begin
            if (rd_data.key >= new_r.key) begin
              stop      = 1'b1;
              pos_nxt   = cidx_r;
              eq_nxt    = (rd_data.key == new_r.key);
              state_nxt = S_EDEC;
            end
          end else if (rd_data.key > hi_r) begin
            stop      = 1'b1;
            state_nxt = S_FIN;
          end else if (rd_data.key >= new_r.key) begin
            if (pend_r && !out_free) begin
              stall = 1'b1;
            end else begin
              push     = pend_r;
              push_res = '{status: res_r.status, key: res_r.key, payload: res_r.payload,
                           nbytes: res_r.nbytes, last: 1'b0};
              res_nxt  = '{status: ST_OK, key: rd_data.key, payload: rd_data.payload,
                           nbytes: rd_data.nbytes, last: 1'b1};
              pend_nxt = 1'b1;
              cnt_nxt  = cnt_r + 1'b1;
              if (cnt_nxt == CNT_W'(RESULT_LIMIT)) begin
                stop      = 1'b1;
                state_nxt = S_FIN;
              end
            end
          end
        end
        if (stall) begin
          dv_nxt = dv_r;
        end else if (!stop) begin
          if (idx_r < occ_r) begin
            rd_en    = 1'b1;
            cidx_nxt = idx_r;
            idx_nxt  = idx_r + 1'b1;
            dv_nxt   = 1'b1;
          end else if (!dv_r) begin
            if (cmd_r == CMD_ENQ) begin
              pos_nxt   = occ_r;
              eq_nxt    = 1'b0;
              state_nxt = S_EDEC;
            end else begin
              state_nxt = S_FIN;
            end
          end
        end
      end
      S_EDEC: begin
        wr_addr = pos_r[AW-1:0];
        wr_data = new_r;
        idx_nxt = occ_r;
        if (eq_r) begin
          wr_en     = 1'b1;
          res_nxt   = '{status: ST_UPDATED, key: new_r.key, payload: new_r.payload,
                        nbytes: new_r.nbytes, last: 1'b1};
          state_nxt = S_FIN;
        end else if (occ_r == OW'(CAPACITY)) begin
          res_nxt   = '{status: ST_FULL, key: new_r.key, payload: '0, nbytes: '0,
                        last: 1'b1};
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_SHU;
        end
      end
      S_SHU: begin
        // Move entries up by one from the top down to the insert slot
        logic [OW-1:0] below;
        below   = idx_r - 1'b1;
        rd_addr = below[AW-1:0];
        if (dv_r) begin
          wr_en   = 1'b1;
          wr_addr = AW'(cidx_r + 1'b1);
          wr_data = rd_data;
        end
        if (idx_r > pos_r) begin
          rd_en    = 1'b1;
          cidx_nxt = below;
          idx_nxt  = below;
          dv_nxt   = 1'b1;
        end else if (!dv_r) begin
          wr_en     = 1'b1;
          wr_addr   = pos_r[AW-1:0];
          wr_data   = new_r;
          occ_nxt   = occ_r + 1'b1;
          res_nxt   = '{status: ST_OK, key: new_r.key, payload: new_r.payload,
                        nbytes: new_r.nbytes, last: 1'b1};
          state_nxt = S_FIN;
        end
      end
      S_DEQ: begin
        // Take the head, then move the rest down by one
        if (dv_r) begin
          if (cidx_r == '0) begin
            res_nxt = '{status: ST_OK, key: rd_data.key, payload: rd_data.payload,
                        nbytes: rd_data.nbytes, last: 1'b1};
          end else begin
            wr_en   = 1'b1;
            wr_addr = AW'(cidx_r - 1'b1);
            wr_data = rd_data;
          end
        end
        if (idx_r < occ_r) begin
          rd_en    = 1'b1;
          cidx_nxt = idx_r;
          idx_nxt  = idx_r + 1'b1;
          dv_nxt   = 1'b1;
        end else if (!dv_r) begin
          occ_nxt   = occ_r - 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          push      = 1'b1;
          push_res  = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold the result item until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = push_res;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    cidx_r    <= cidx_nxt;
    pos_r     <= pos_nxt;
    eq_r      <= eq_nxt;
    pend_r    <= pend_nxt;
    cnt_r     <= cnt_nxt;
    cmd_r     <= cmd_nxt;
    hi_r      <= hi_nxt;
    new_r     <= new_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = out_res_r.status;
  assign out_ch.out_key           = out_res_r.key;
  assign out_ch.out_payload       = out_res_r.payload;
  assign out_ch.out_payload_bytes = out_res_r.nbytes;
  assign out_ch.last              = out_res_r.last;

  `SKPQ_ASSERT_NOW(a_occ_bound, 1'b1, occ_r <= OW'(CAPACITY), "occupancy above capacity")
  `SKPQ_ASSERT_NOW(a_port_clash, rd_en && wr_en, rd_addr != wr_addr, "read and write clash")
  `SKPQ_ASSERT_NOW(a_mid_range, push && !push_res.last, cmd_r == CMD_RANGE,
    "non-final item outside range query")
  `SKPQ_ASSERT_NEXT(a_push_taken, push && !out_free, 1'b0, "item pushed into busy output")
endmodule
`default_nettype wire
